// File: rtl/multi_lorentzian_spectrum_eval_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef MULTI_LORENTZIAN_SPECTRUM_EVAL_TOP_MACROS_SVH
`define MULTI_LORENTZIAN_SPECTRUM_EVAL_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MLSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define MLSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mlse_pkg.sv
package mlse_pkg;

  localparam int X_W      = 20;
  localparam int AMP_W    = 20;
  localparam int OUT_W    = 24;
  localparam int SUM_W    = 26;
  localparam int GATE_W   = 7;
  localparam int POOL_W   = 60;
  localparam int MASK_W   = 14;
  localparam int IDX_W    = 4;
  localparam int POOL_SLOTS = 6;
  localparam int Q_W      = 20;
  localparam int W2_W     = 39;
  localparam int D2_W     = 41;
  localparam int DEN_W    = 42;
  localparam int REM_W    = 59;
  localparam int DIV_W    = 62;

  localparam logic [IDX_W-1:0] REG_BASELINE = 4'd0;
  localparam logic [IDX_W-1:0] REG_MASK     = 4'd7;
  localparam logic [MASK_W-1:0] MASK_RESET  = 14'h3FFF;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8388608);

  typedef struct packed {
    logic signed [X_W-1:0] offset;
    logic                  single_mode;
    logic                  last_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] model_value;
    logic                    saturated;
    logic                    last_point;
  } out_item_t;

  // Data handed from one cell to the next
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [GATE_W-1:0]       gate;
    logic signed [X_W-1:0]   x;
    logic signed [SUM_W-1:0] sum;
  } chain_t;

endpackage

// File: rtl/mlse_cell.sv
module mlse_cell import mlse_pkg::*; #(
  parameter int GATE_BIT = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                cfg_we_i,
  input  logic [POOL_W-1:0]   cfg_data_i,
  input  chain_t              chain_i,
  output chain_t              chain_o
);

  localparam int DIV_STEPS = Q_W;
  localparam int LAT = 4 + DIV_STEPS + 1;

  logic [POOL_W-1:0] pool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
    end else if (cfg_we_i) begin
      pool_q <= cfg_data_i;
    end
  end

  chain_t sb_q [LAT];

  logic [AMP_W-1:0] amp_u, w_u;
  logic signed [X_W-1:0] c_s;
  assign amp_u = pool_q[59:40];
  assign w_u   = pool_q[39:20];
  assign c_s   = $signed(pool_q[19:0]);

  // stage 0: difference and magnitudes
  logic signed [X_W:0] d0_q;
  logic [AMP_W-1:0] absw0_q, mag0_q;
  logic neg0_q;
  // stage 1: squares
  logic [W2_W-1:0] w2_1_q;
  logic [D2_W-1:0] d2_1_q;
  logic [AMP_W-1:0] mag1_q;
  logic neg1_q;
  // stage 2: denominator and partial products
  logic [DEN_W-1:0] den2_q;
  logic [39:0] pplo2_q;
  logic [38:0] pphi2_q;
  logic zero2_q, neg2_q;
  // divider pipeline
  logic [REM_W-1:0] rem_q [DIV_STEPS+1];
  logic [DEN_W-1:0] den_q [DIV_STEPS+1];
  logic [Q_W-1:0]   quo_q [DIV_STEPS+1];
  logic             zr_q  [DIV_STEPS+1];
  logic             ng_q  [DIV_STEPS+1];

  logic signed [2*X_W+1:0] dd;
  logic [REM_W-1:0] num;
  assign dd  = d0_q * d0_q;
  assign num = REM_W'(pplo2_q) + (REM_W'(pphi2_q) << 20);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q    <= (X_W+1)'(chain_i.x) - (X_W+1)'(c_s);
      absw0_q <= w_u[AMP_W-1] ? (~w_u + 1'b1) : w_u;
      mag0_q  <= amp_u[AMP_W-1] ? (~amp_u + 1'b1) : amp_u;
      neg0_q  <= amp_u[AMP_W-1];

      w2_1_q  <= W2_W'(absw0_q * absw0_q);
      d2_1_q  <= dd[D2_W-1:0];
      mag1_q  <= mag0_q;
      neg1_q  <= neg0_q;

      den2_q  <= DEN_W'(w2_1_q) + DEN_W'(d2_1_q);
      pplo2_q <= mag1_q * w2_1_q[19:0];
      pphi2_q <= mag1_q * w2_1_q[38:20];
      zero2_q <= (w2_1_q == '0);
      neg2_q  <= neg1_q;

      // add half the divisor for round half away from zero
      rem_q[0] <= num + REM_W'(den2_q >> 1);
      den_q[0] <= den2_q;
      quo_q[0] <= '0;
      zr_q[0]  <= zero2_q;
      ng_q[0]  <= neg2_q;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [DIV_W-1:0] trial;
    logic take;
    assign trial = DIV_W'(den_q[k-1]) << (DIV_STEPS - k);
    assign take  = DIV_W'(rem_q[k-1]) >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? REM_W'(DIV_W'(rem_q[k-1]) - trial) : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (take ? (Q_W'(1) << (DIV_STEPS - k)) : '0);
        den_q[k] <= den_q[k-1];
        zr_q[k]  <= zr_q[k-1];
        ng_q[k]  <= ng_q[k-1];
      end
    end
  end

  logic signed [SUM_W-1:0] term_mag, term;
  always_comb begin
    term_mag = $signed(SUM_W'(quo_q[DIV_STEPS]));
    if (zr_q[DIV_STEPS] || !sb_q[LAT-2].gate[GATE_BIT]) begin
      term = '0;
    end else if (ng_q[DIV_STEPS]) begin
      term = -term_mag;
    end else begin
      term = term_mag;
    end
  end

  chain_t tail_d;
  always_comb begin
    tail_d     = sb_q[LAT-2];
    tail_d.sum = sb_q[LAT-2].sum + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) sb_q[i] <= '0;
    end else if (en_i) begin
      sb_q[0] <= chain_i;
      for (int i = 1; i < LAT - 1; i++) sb_q[i] <= sb_q[i-1];
      sb_q[LAT-1] <= tail_d;
    end
  end

  assign chain_o = sb_q[LAT-1];

endmodule

// File: rtl/multi_lorentzian_spectrum_eval_top.sv
// Sum-of-Lorentzians spectrum evaluator.
// Input channel (in_valid_i / in_stall_o / in_item_i): one frequency offset per
// transaction, plus single_mode and a last_offset marker.
// Output channel (out_valid_o / out_stall_i / out_item_o): one model value per
// input, in order, with a saturation flag and the copied marker.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; always
// ready. Write only while no transaction is in flight.
// Structure: one cell per pool in a chain; each cell carries the running sum
// through a 25-stage pipeline (squares, partial products, a 20-step restoring
// divider, then the add). The last cell feeds the output register.
// Throughput: one offset per cycle while no stalled result holds the pipeline,
// set by the fully pipelined divider. When the receiver stalls a valid result,
// the whole pipeline holds and in_stall_o rises in the same cycle; it is otherwise low.
// Reset clears the pipeline valids, the pool registers and the baseline, and
// sets the mask to all ones. No clearing pass is needed.
module multi_lorentzian_spectrum_eval_top import mlse_pkg::*; #(
  parameter int LORENTZ_POOLS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [POOL_W-1:0]  cfg_data_i
);

  logic signed [AMP_W-1:0] baseline_q;
  logic [MASK_W-1:0]       mask_q;
  logic                    en;
  logic                    out_valid_q;
  out_item_t               out_q;
  chain_t                  chain [LORENTZ_POOLS+1];
  logic [GATE_W-1:0]       gate;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      mask_q     <= MASK_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_BASELINE) begin
        baseline_q <= $signed(cfg_data_i[AMP_W-1:0]);
      end
      if (cfg_index_i == REG_MASK) begin
        mask_q <= cfg_data_i[MASK_W-1:0];
      end
    end
  end

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    gate = mask_q[GATE_W-1:0];
    if (in_item_i.single_mode) begin
      gate = gate & mask_q[MASK_W-1:GATE_W];
    end
    chain[0].valid = in_valid_i;
    chain[0].last  = in_item_i.last_offset;
    chain[0].gate  = gate;
    chain[0].x     = in_item_i.offset;
    chain[0].sum   = gate[0] ? SUM_W'(baseline_q) : '0;
  end

  for (genvar p = 0; p < LORENTZ_POOLS; p++) begin : g_cell
    mlse_cell #(
      .GATE_BIT(p + 1)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .cfg_we_i  (cfg_valid_i && (cfg_index_i == IDX_W'(p + 1))),
      .cfg_data_i(cfg_data_i),
      .chain_i   (chain[p]),
      .chain_o   (chain[p+1])
    );
  end

  chain_t tail;
  out_item_t res;
  assign tail = chain[LORENTZ_POOLS];

  always_comb begin
    res.last_point = tail.last;
    if (tail.sum > OUT_MAX) begin
      res.model_value = OUT_W'(OUT_MAX);
      res.saturated   = 1'b1;
    end else if (tail.sum < OUT_MIN) begin
      res.model_value = OUT_W'(OUT_MIN);
      res.saturated   = 1'b1;
    end else begin
      res.model_value = tail.sum[OUT_W-1:0];
      res.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/mlse_checker.sv
`include "multi_lorentzian_spectrum_eval_top_macros.svh"

module mlse_port_checker import mlse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o,
  input logic      cfg_ready_o
);

  // input only held back by a stalled result
  `MLSE_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `MLSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `MLSE_ASSERT_IMP(a_sat_value, clk_i, rst_ni, out_valid_o && out_item_o.saturated,
                   out_item_o.model_value == 24'sh7FFFFF || out_item_o.model_value == 24'sh800000)
  `MLSE_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)

endmodule

bind multi_lorentzian_spectrum_eval_top mlse_port_checker u_mlse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o),
  .cfg_ready_o(cfg_ready_o)
);
